// ----- sv/owmm_pkg.sv -----
// Shared types and constants for the omni wheel motor mixer.
package owmm_pkg;

    // Command codes (tuser bits [1:0])
    localparam logic [1:0] CMD_PRESET    = 2'd0;
    localparam logic [1:0] CMD_DIRECTION = 2'd1;
    localparam logic [1:0] CMD_VECTOR    = 2'd2;

    // Preset move modes (tuser bits [5:2])
    localparam logic [3:0] MODE_STOP      = 4'd0;
    localparam logic [3:0] MODE_FWD       = 4'd1;
    localparam logic [3:0] MODE_BACK      = 4'd2;
    localparam logic [3:0] MODE_LEFT      = 4'd3;
    localparam logic [3:0] MODE_RIGHT     = 4'd4;
    localparam logic [3:0] MODE_ROT_LEFT  = 4'd5;
    localparam logic [3:0] MODE_ROT_RIGHT = 4'd6;
    localparam logic [3:0] MODE_DIAG_FL   = 4'd7;
    localparam logic [3:0] MODE_DIAG_FR   = 4'd8;
    localparam logic [3:0] MODE_DIAG_BL   = 4'd9;
    localparam logic [3:0] MODE_DIAG_BR   = 4'd10;

    // Register indexes
    localparam logic [1:0] CFG_RADIUS  = 2'd0;
    localparam logic [1:0] CFG_MAX_LIN = 2'd1;
    localparam logic [1:0] CFG_MAX_ANG = 2'd2;

    localparam logic [15:0] RADIUS_RESET  = 16'd9830;
    localparam logic [14:0] MAX_LIN_RESET = 15'd10240;
    localparam logic [14:0] MAX_ANG_RESET = 15'd12868;

    // Direction to phase: floor(dir * 2^32 / DIRECTION_STEPS)
    localparam longint DIRECTION_STEPS = 3600;
    localparam logic [31:0] DIR_BASE  = 32'((64'd1 << 32) / DIRECTION_STEPS);
    localparam logic [11:0] DIR_REM   = 12'((64'd1 << 32) % DIRECTION_STEPS);
    localparam logic [27:0] DIR_RECIP =
        28'(((64'd1 << 36) + DIRECTION_STEPS - 1) / DIRECTION_STEPS);

    localparam logic signed [16:0] DIAG_Q16       = 17'sd46334;
    localparam logic signed [16:0] HALF_ROOT3_Q16 = 17'sd56756;

    localparam int CORDIC_STEPS = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    localparam int SQRT_STEPS = 25;
    localparam int LDIV_STEPS = 17;
    localparam int MDIV_STEPS = 15;
    localparam logic [14:0] MOTOR_FULL = 15'd16384;

    typedef logic signed [17:0] t_vel;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         mode;
        logic signed [15:0] spd;
        logic [11:0]        dir;
        t_vel               vx;
        t_vel               vy;
        t_vel               w;
    } t_item;

endpackage

// ----- sv/omni_wheel_motor_mixer_unit.sv -----
// Three-wheel omni inverse kinematics mixer, fully pipelined.
// Throughput: one word per cycle; every stage advances while the output register
// is empty or being taken, so a stall at the output freezes the whole pipe.
// Reset (i_rst_n low, synchronous) empties all stages and loads register defaults.
module omni_wheel_motor_mixer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] speed, [27:16] direction_tenths, [43:28] vel_x, [59:44] vel_y,
    // [75:60] turn_rate, [79:76] zero
    input  logic [79:0] i_s_axis_tdata,
    // [1:0] command, [5:2] move_mode
    input  logic [5:0]  i_s_axis_tuser,
    // motor stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] motor_one, [31:16] motor_two, [47:32] motor_three
    output logic [47:0] o_m_axis_tdata
);

    localparam int NC = owmm_pkg::CORDIC_STEPS;
    localparam int NS = owmm_pkg::SQRT_STEPS;
    localparam int NL = owmm_pkg::LDIV_STEPS;
    localparam int NM = owmm_pkg::MDIV_STEPS;

    // ---------------------------------------------------------------------
    // Config registers. r_lim is registered from r_max_lin and r_lim_sq from r_lim;
    // the user must change config only while the pipe is empty; the block does not enforce it.
    // ---------------------------------------------------------------------
    logic [15:0] r_radius;
    logic [14:0] r_max_lin;
    logic [14:0] r_max_ang;
    logic [14:0] r_lim;
    logic [29:0] r_lim_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= owmm_pkg::RADIUS_RESET;
            r_max_lin <= owmm_pkg::MAX_LIN_RESET;
            r_max_ang <= owmm_pkg::MAX_ANG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                owmm_pkg::CFG_RADIUS:  r_radius  <= i_cfg_wdata;
                owmm_pkg::CFG_MAX_LIN: r_max_lin <= i_cfg_wdata[14:0];
                owmm_pkg::CFG_MAX_ANG: r_max_ang <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // zero linear limit behaves as one
    always_ff @(posedge i_clk) begin
        r_lim    <= (r_max_lin == 15'd0) ? 15'd1 : r_max_lin;
        r_lim_sq <= r_lim * r_lim;
    end

    // global advance: whole pipe moves when the output slot frees up
    logic w_adv;
    logic r_out_valid;
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // ---------------------------------------------------------------------
    // Valid bits
    // ---------------------------------------------------------------------
    logic          r_in_v, r_dec_v, r_ph_v;
    logic [NC:0]   r_cv;
    logic          r_qm_v, r_mul_v, r_rnd_v, r_sq_v;
    logic [NS:0]   r_sv;
    logic [NL:0]   r_dv;
    logic          r_fin_v, r_prd_v, r_sum_v;
    logic [NM:0]   r_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v      <= 1'b0;
            r_dec_v     <= 1'b0;
            r_ph_v      <= 1'b0;
            r_cv        <= '0;
            r_qm_v      <= 1'b0;
            r_mul_v     <= 1'b0;
            r_rnd_v     <= 1'b0;
            r_sq_v      <= 1'b0;
            r_sv        <= '0;
            r_dv        <= '0;
            r_fin_v     <= 1'b0;
            r_prd_v     <= 1'b0;
            r_sum_v     <= 1'b0;
            r_mv        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_v      <= i_s_axis_tvalid;
            r_dec_v     <= r_in_v;
            r_ph_v      <= r_dec_v;
            r_cv        <= {r_cv[NC-1:0], r_ph_v};
            r_qm_v      <= r_cv[NC];
            r_mul_v     <= r_qm_v;
            r_rnd_v     <= r_mul_v;
            r_sq_v      <= r_rnd_v;
            r_sv        <= {r_sv[NS-1:0], r_sq_v};
            r_dv        <= {r_dv[NL-1:0], r_sv[NS]};
            r_fin_v     <= r_dv[NL];
            r_prd_v     <= r_fin_v;
            r_sum_v     <= r_prd_v;
            r_mv        <= {r_mv[NM-1:0], r_sum_v};
            r_out_valid <= r_mv[NM];
        end
    end

    // ---------------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------------
    owmm_pkg::t_item r_in_item;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_item.cmd  <= i_s_axis_tuser[1:0];
            r_in_item.mode <= i_s_axis_tuser[5:2];
            r_in_item.spd  <= $signed(i_s_axis_tdata[15:0]);
            r_in_item.dir  <= i_s_axis_tdata[27:16];
            r_in_item.vx   <= 18'($signed(i_s_axis_tdata[43:28]));
            r_in_item.vy   <= 18'($signed(i_s_axis_tdata[59:44]));
            r_in_item.w    <= 18'($signed(i_s_axis_tdata[75:60]));
        end
    end

    // ---------------------------------------------------------------------
    // Decode: presets and raw vectors; direction phase products
    // ---------------------------------------------------------------------
    logic signed [32:0] w_dprod;
    logic [32:0]        w_dmag;
    logic [16:0]        w_dq;
    owmm_pkg::t_vel     w_diag, w_spd, w_nspd;
    owmm_pkg::t_item    n_dec_item;
    logic [43:0]        w_base_full;
    logic [23:0]        w_rem_full;

    assign w_dprod     = r_in_item.spd * owmm_pkg::DIAG_Q16;
    assign w_dmag      = w_dprod[32] ? 33'(-w_dprod) : 33'(w_dprod);
    assign w_dq        = 17'((w_dmag + 33'd32768) >> 16);
    assign w_diag      = w_dprod[32] ? -$signed({1'b0, w_dq}) : $signed({1'b0, w_dq});
    assign w_spd       = 18'(r_in_item.spd);
    assign w_nspd      = -w_spd;
    assign w_base_full = 44'(r_in_item.dir) * 44'(owmm_pkg::DIR_BASE);
    assign w_rem_full  = 24'(r_in_item.dir) * 24'(owmm_pkg::DIR_REM);

    always_comb begin
        n_dec_item    = r_in_item;
        n_dec_item.vx = '0;
        n_dec_item.vy = '0;
        n_dec_item.w  = '0;
        case (r_in_item.cmd)
            owmm_pkg::CMD_PRESET: begin
                unique case (r_in_item.mode)
                    owmm_pkg::MODE_FWD:       n_dec_item.vy = w_spd;
                    owmm_pkg::MODE_BACK:      n_dec_item.vy = w_nspd;
                    owmm_pkg::MODE_LEFT:      n_dec_item.vx = w_nspd;
                    owmm_pkg::MODE_RIGHT:     n_dec_item.vx = w_spd;
                    owmm_pkg::MODE_ROT_LEFT:  n_dec_item.w  = w_spd;
                    owmm_pkg::MODE_ROT_RIGHT: n_dec_item.w  = w_nspd;
                    owmm_pkg::MODE_DIAG_FL: begin
                        n_dec_item.vx = -w_diag;
                        n_dec_item.vy = w_diag;
                    end
                    owmm_pkg::MODE_DIAG_FR: begin
                        n_dec_item.vx = w_diag;
                        n_dec_item.vy = w_diag;
                    end
                    owmm_pkg::MODE_DIAG_BL: begin
                        n_dec_item.vx = -w_diag;
                        n_dec_item.vy = -w_diag;
                    end
                    owmm_pkg::MODE_DIAG_BR: begin
                        n_dec_item.vx = w_diag;
                        n_dec_item.vy = -w_diag;
                    end
                    default: ;  // stop and unknown modes
                endcase
            end
            owmm_pkg::CMD_VECTOR: begin
                n_dec_item.vx = r_in_item.vx;
                n_dec_item.vy = r_in_item.vy;
                n_dec_item.w  = r_in_item.w;
            end
            default: ;  // direction filled in after CORDIC; unused code gives zero
        endcase
    end

    owmm_pkg::t_item r_dec_item;
    logic [31:0]     r_dec_base;
    logic [23:0]     r_dec_x;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dec_item <= n_dec_item;
            r_dec_base <= w_base_full[31:0];
            r_dec_x    <= w_rem_full;
        end
    end

    // remainder part of phase: floor(x / DIRECTION_STEPS) by reciprocal
    logic [51:0]     w_phq_full;
    owmm_pkg::t_item r_ph_item;
    logic [31:0]     r_ph_base;
    logic [15:0]     r_ph_q;

    assign w_phq_full = 52'(r_dec_x) * 52'(owmm_pkg::DIR_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ph_item <= r_dec_item;
            r_ph_base <= r_dec_base;
            r_ph_q    <= w_phq_full[51:36];
        end
    end

    // ---------------------------------------------------------------------
    // CORDIC rotation, one micro-rotation per stage (phase in turns)
    // ---------------------------------------------------------------------
    logic signed [33:0] r_cx [0:NC];
    logic signed [33:0] r_cy [0:NC];
    logic signed [32:0] r_cz [0:NC];
    logic [1:0]         r_cq [0:NC];
    owmm_pkg::t_item    r_ci [0:NC];
    logic [31:0]        w_phase;

    assign w_phase = r_ph_base + 32'(r_ph_q);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cx[0] <= owmm_pkg::CORDIC_GAIN;
            r_cy[0] <= '0;
            r_cz[0] <= $signed({3'b000, w_phase[29:0]});
            r_cq[0] <= w_phase[31:30];
            r_ci[0] <= r_ph_item;
        end
    end

    for (genvar k = 0; k < NC; k++) begin : g_cordic
        logic signed [32:0] w_at;
        assign w_at = $signed({3'b000, owmm_pkg::ATAN_TURNS[k]});
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (r_cz[k] >= 0) begin
                    r_cx[k+1] <= r_cx[k] - (r_cy[k] >>> k);
                    r_cy[k+1] <= r_cy[k] + (r_cx[k] >>> k);
                    r_cz[k+1] <= r_cz[k] - w_at;
                end else begin
                    r_cx[k+1] <= r_cx[k] + (r_cy[k] >>> k);
                    r_cy[k+1] <= r_cy[k] - (r_cx[k] >>> k);
                    r_cz[k+1] <= r_cz[k] + w_at;
                end
                r_cq[k+1] <= r_cq[k];
                r_ci[k+1] <= r_ci[k];
            end
        end
    end

    // quadrant fold
    logic signed [33:0] r_qm_c, r_qm_s;
    owmm_pkg::t_item    r_qm_item;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_qm_item <= r_ci[NC];
            case (r_cq[NC])
                2'd0: begin r_qm_c <= r_cx[NC];  r_qm_s <= r_cy[NC];  end
                2'd1: begin r_qm_c <= -r_cy[NC]; r_qm_s <= r_cx[NC];  end
                2'd2: begin r_qm_c <= -r_cx[NC]; r_qm_s <= -r_cy[NC]; end
                default: begin r_qm_c <= r_cy[NC]; r_qm_s <= -r_cx[NC]; end
            endcase
        end
    end

    // speed times cos / sin
    logic signed [49:0] w_pc, w_ps;
    logic signed [49:0] r_mul_pc, r_mul_ps;
    owmm_pkg::t_item    r_mul_item;

    assign w_pc = r_qm_item.spd * r_qm_c;
    assign w_ps = r_qm_item.spd * r_qm_s;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mul_pc   <= w_pc;
            r_mul_ps   <= w_ps;
            r_mul_item <= r_qm_item;
        end
    end

    // round Q20.30 product back to speed units, half away from zero
    function automatic owmm_pkg::t_vel rnd30(input logic signed [49:0] p);
        logic [49:0] m;
        logic [19:0] q;
        m = p[49] ? 50'(-p) : 50'(p);
        q = 20'((m + (50'd1 << 29)) >> 30);
        rnd30 = p[49] ? -$signed(q[17:0]) : $signed(q[17:0]);
    endfunction

    owmm_pkg::t_item n_rnd_item;
    owmm_pkg::t_item r_rnd_item;

    always_comb begin
        n_rnd_item = r_mul_item;
        if (r_mul_item.cmd == owmm_pkg::CMD_DIRECTION) begin
            n_rnd_item.vx = rnd30(r_mul_pc);
            n_rnd_item.vy = rnd30(r_mul_ps);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rnd_item <= n_rnd_item;
        end
    end

    // ---------------------------------------------------------------------
    // Planar magnitude and limit test
    // ---------------------------------------------------------------------
    logic signed [35:0] r_sqx, r_sqy;
    owmm_pkg::t_item    r_sq_item;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sqx     <= r_rnd_item.vx * r_rnd_item.vx;
            r_sqy     <= r_rnd_item.vy * r_rnd_item.vy;
            r_sq_item <= r_rnd_item;
        end
    end

    logic [32:0] w_mag2;
    assign w_mag2 = 33'(r_sqx) + 33'(r_sqy);

    // sqrt stage 0 holds the radicand mag2 << 16
    logic [49:0]     r_srad [0:NS];
    logic [25:0]     r_srem [0:NS];
    logic [24:0]     r_sroot[0:NS];
    logic            r_sbig [0:NS];
    owmm_pkg::t_item r_si   [0:NS];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_srad[0]  <= {1'b0, w_mag2, 16'd0};
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            r_sbig[0]  <= (w_mag2 > 33'(r_lim_sq));
            r_si[0]    <= r_sq_item;
        end
    end

    // restoring square root, one root bit per stage
    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        logic [27:0] w_t, w_trial;
        logic        w_ge;
        assign w_t     = {r_srem[k], r_srad[k][49:48]};
        assign w_trial = {1'b0, r_sroot[k], 2'b01};
        assign w_ge    = (w_t >= w_trial);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_srad[k+1]  <= {r_srad[k][47:0], 2'b00};
                r_srem[k+1]  <= w_ge ? 26'(w_t - w_trial) : w_t[25:0];
                r_sroot[k+1] <= {r_sroot[k][23:0], w_ge};
                r_sbig[k+1]  <= r_sbig[k];
                r_si[k+1]    <= r_si[k];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Scale-down division: round(|v| * lim * 256 / mq), two lanes
    // ---------------------------------------------------------------------
    logic [32:0] w_mx, w_my;
    logic [41:0] w_nx, w_ny;
    logic [17:0] w_ax, w_ay;
    owmm_pkg::t_item w_sitem;

    assign w_sitem = r_si[NS];
    assign w_ax    = w_sitem.vx[17] ? 18'(-w_sitem.vx) : 18'(w_sitem.vx);
    assign w_ay    = w_sitem.vy[17] ? 18'(-w_sitem.vy) : 18'(w_sitem.vy);
    assign w_mx    = 33'(w_ax) * 33'(r_lim);
    assign w_my    = 33'(w_ay) * 33'(r_lim);
    assign w_nx    = {1'b0, w_mx, 8'd0} + 42'(r_sroot[NS] >> 1);
    assign w_ny    = {1'b0, w_my, 8'd0} + 42'(r_sroot[NS] >> 1);

    logic [24:0]     r_dd  [0:NL];
    logic [24:0]     r_dxr [0:NL];
    logic [16:0]     r_dxl [0:NL];
    logic [16:0]     r_dxq [0:NL];
    logic [24:0]     r_dyr [0:NL];
    logic [16:0]     r_dyl [0:NL];
    logic [16:0]     r_dyq [0:NL];
    logic            r_dbig[0:NL];
    owmm_pkg::t_item r_di  [0:NL];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dd[0]   <= r_sroot[NS];
            r_dxr[0]  <= w_nx[41:17];
            r_dxl[0]  <= w_nx[16:0];
            r_dxq[0]  <= '0;
            r_dyr[0]  <= w_ny[41:17];
            r_dyl[0]  <= w_ny[16:0];
            r_dyq[0]  <= '0;
            r_dbig[0] <= r_sbig[NS];
            r_di[0]   <= w_sitem;
        end
    end

    for (genvar j = 0; j < NL; j++) begin : g_ldiv
        logic [25:0] w_tx, w_ty, w_d;
        logic        w_gx, w_gy;
        assign w_d  = {1'b0, r_dd[j]};
        assign w_tx = {r_dxr[j], r_dxl[j][16]};
        assign w_ty = {r_dyr[j], r_dyl[j][16]};
        assign w_gx = (w_tx >= w_d);
        assign w_gy = (w_ty >= w_d);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dd[j+1]   <= r_dd[j];
                r_dxr[j+1]  <= w_gx ? 25'(w_tx - w_d) : w_tx[24:0];
                r_dxl[j+1]  <= {r_dxl[j][15:0], 1'b0};
                r_dxq[j+1]  <= {r_dxq[j][15:0], w_gx};
                r_dyr[j+1]  <= w_gy ? 25'(w_ty - w_d) : w_ty[24:0];
                r_dyl[j+1]  <= {r_dyl[j][15:0], 1'b0};
                r_dyq[j+1]  <= {r_dyq[j][15:0], w_gy};
                r_dbig[j+1] <= r_dbig[j];
                r_di[j+1]   <= r_di[j];
            end
        end
    end

    // apply scale where over the limit, clamp omega
    owmm_pkg::t_item w_ditem;
    owmm_pkg::t_vel  w_amax;
    owmm_pkg::t_item n_fin_item;
    owmm_pkg::t_item r_fin_item;

    assign w_ditem = r_di[NL];
    assign w_amax  = $signed({3'b000, r_max_ang});

    always_comb begin
        n_fin_item = w_ditem;
        if (r_dbig[NL]) begin
            n_fin_item.vx = w_ditem.vx[17] ? -$signed({1'b0, r_dxq[NL]})
                                           : $signed({1'b0, r_dxq[NL]});
            n_fin_item.vy = w_ditem.vy[17] ? -$signed({1'b0, r_dyq[NL]})
                                           : $signed({1'b0, r_dyq[NL]});
        end
        if (w_ditem.w > w_amax)
            n_fin_item.w = w_amax;
        else if (w_ditem.w < -w_amax)
            n_fin_item.w = -w_amax;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fin_item <= n_fin_item;
        end
    end

    // ---------------------------------------------------------------------
    // Wheel projection
    // ---------------------------------------------------------------------
    logic signed [34:0] r_prd_pvy, r_prd_rw;
    owmm_pkg::t_vel     r_prd_vx;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prd_pvy <= r_fin_item.vy * owmm_pkg::HALF_ROOT3_Q16;
            r_prd_rw  <= r_fin_item.w * $signed({1'b0, r_radius});
            r_prd_vx  <= r_fin_item.vx;
        end
    end

    logic signed [37:0] w_evx, w_pvy, w_rw, w_v1, w_v2, w_v3;
    logic signed [37:0] r_n [0:2];

    assign w_evx = 38'(r_prd_vx);
    assign w_pvy = 38'(r_prd_pvy);
    assign w_rw  = 38'(r_prd_rw);
    assign w_v1  = -(w_evx <<< 15) - w_pvy + w_rw;
    assign w_v2  = -(w_evx <<< 15) + w_pvy + w_rw;
    assign w_v3  = (w_evx <<< 16) + w_rw;

    // motor 2 negated; motor 3 negated and weighted 3/2 (divisor doubled)
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_n[0] <= w_v1;
            r_n[1] <= -w_v2;
            r_n[2] <= -(w_v3 + (w_v3 <<< 1));
        end
    end

    // ---------------------------------------------------------------------
    // Motor division: round(n / d), saturating at full scale, three lanes
    // ---------------------------------------------------------------------
    logic [17:0] w_md [0:2];
    assign w_md[0] = {1'b0, r_lim, 2'b00};
    assign w_md[1] = {1'b0, r_lim, 2'b00};
    assign w_md[2] = {r_lim, 3'b000};

    logic [17:0] r_mr  [0:NM][0:2];
    logic [14:0] r_ml  [0:NM][0:2];
    logic [14:0] r_mq  [0:NM][0:2];
    logic        r_mneg[0:NM][0:2];
    logic        r_movf[0:NM][0:2];
    logic [17:0] r_mdd [0:NM][0:2];

    for (genvar l = 0; l < 3; l++) begin : g_mlane
        logic [37:0] w_abs;
        logic [38:0] w_num;
        logic        w_ovf;
        assign w_abs = r_n[l][37] ? 38'(-r_n[l]) : 38'(r_n[l]);
        assign w_num = 39'(w_abs) + 39'(w_md[l] >> 1);
        assign w_ovf = (w_num[38:15] >= 24'(w_md[l]));

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_mr[0][l]   <= w_ovf ? 18'd0 : w_num[32:15];
                r_ml[0][l]   <= w_num[14:0];
                r_mq[0][l]   <= '0;
                r_mneg[0][l] <= r_n[l][37];
                r_movf[0][l] <= w_ovf;
                r_mdd[0][l]  <= w_md[l];
            end
        end

        for (genvar m = 0; m < NM; m++) begin : g_mstep
            logic [18:0] w_t, w_d;
            logic        w_ge;
            assign w_d  = {1'b0, r_mdd[m][l]};
            assign w_t  = {r_mr[m][l], r_ml[m][l][14]};
            assign w_ge = (w_t >= w_d);
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_mr[m+1][l]   <= w_ge ? 18'(w_t - w_d) : w_t[17:0];
                    r_ml[m+1][l]   <= {r_ml[m][l][13:0], 1'b0};
                    r_mq[m+1][l]   <= {r_mq[m][l][13:0], w_ge};
                    r_mneg[m+1][l] <= r_mneg[m][l];
                    r_movf[m+1][l] <= r_movf[m][l];
                    r_mdd[m+1][l]  <= r_mdd[m][l];
                end
            end
        end
    end

    // clamp to +-1.0 and register the output word
    logic signed [15:0] r_out_m [0:2];

    for (genvar l = 0; l < 3; l++) begin : g_out
        logic [14:0] w_mag;
        assign w_mag = (r_movf[NM][l] || r_mq[NM][l] > owmm_pkg::MOTOR_FULL)
                     ? owmm_pkg::MOTOR_FULL : r_mq[NM][l];
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_out_m[l] <= r_mneg[NM][l] ? -$signed({1'b0, w_mag})
                                            : $signed({1'b0, w_mag});
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_m[2], r_out_m[1], r_out_m[0]};

endmodule
